[rtl/ibmh_pkg.sv]
// Package for the indexed binary min/max heap.
// Holds widths, action and status codes, and the sequencer state type.
`default_nettype none
package ibmh_pkg;
    localparam int SLOT_BITS = 6;
    localparam int KEY_W     = 32;
    localparam int ID_W      = 6;
    localparam int CNT_W     = 7;
    localparam logic [CNT_W-1:0] CAPACITY = 7'd64;

    typedef enum logic [1:0] {
        ACT_PUSH     = 2'd0,
        ACT_DECREASE = 2'd1,
        ACT_POP      = 2'd2,
        ACT_CONTAINS = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DUP      = 3'd3,
        ST_ABSENT   = 3'd4,
        ST_NOT_IMPR = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_DEC_READ,
        S_DEC_CHECK,
        S_POP_LAST,
        S_POP_ROOT,
        S_UP_READ,
        S_UP_CMP,
        S_DN_READ_L,
        S_DN_READ_R,
        S_DN_CMP,
        S_TOP_READ,
        S_TOP_WAIT,
        S_OUT
    } state_t;

    // Compare: a before-or-equal b under the current order.
    function automatic logic before_eq(input logic desc, input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
        before_eq = desc ? (a >= b) : (a <= b);
    endfunction
endpackage
`default_nettype wire

[rtl/indexed_binary_min_heap_top.sv]
// Indexed binary heap with a position table per id, as one sequencer.
// Depends on ibmh_pkg for widths, codes and the state type.
//
// Usage: requests enter on s_axis (tdata = action[1:0], entry_id[7:2],
// entry_key[39:8]). Each request yields one result on m_axis (tdata =
// status[2:0], top_valid[3], top_id[9:4], top_key[41:10],
// entry_count[48:42], found[49], zero fill to 56 bits).
// One request is worked at a time. The heap lives in a 64-entry slot
// memory and a 64-entry position memory, both with registered reads.
// A request passes a lookup; a pop then reads the last entry and the
// root, a decrease checks the new key; sift-up levels (read parent,
// compare) or sift-down levels (read left, read right, compare) follow,
// then a root read, a wait and the output state. The next request is
// taken at the earliest in the cycle the result appears.
// The result sits in an output register; a new request is taken once the
// previous result has been taken or while it is leaving in the same cycle.
// A stalled receiver holds the result and the block. Reset empties the
// heap (all id valid bits cleared at once, count zero) and selects
// ascending order; no clearing pass is needed.
// cfg_we/cfg_wdata write order_descending; write only while idle.
`default_nettype none
module indexed_binary_min_heap_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_wdata,      // order_descending
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // action, entry_id, entry_key
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata    // status, top_valid, top_id, top_key,
                                        // entry_count, found
);
    localparam int KW = ibmh_pkg::KEY_W;
    localparam int IW = ibmh_pkg::ID_W;
    localparam int SW = ibmh_pkg::SLOT_BITS;
    localparam int CW = ibmh_pkg::CNT_W;

    // Storage: heap slots {id,key}, position per id, valid per id.
    logic [IW+KW-1:0] heap_mem [0:63];
    logic [SW-1:0]    pos_mem  [0:63];
    logic [63:0]      present_reg, present_next;

    logic             desc_reg;
    ibmh_pkg::state_t state_reg, state_next;
    logic [1:0]       act_reg, act_next;
    logic [IW-1:0]    id_reg, id_next;
    logic [KW-1:0]    key_reg, key_next;      // key of the moving entry
    logic [IW-1:0]    mid_reg, mid_next;      // id of the moving entry
    logic [SW-1:0]    cur_reg, cur_next;      // slot of the moving entry
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [2:0]       st_reg, st_next;
    logic [IW+KW-1:0] lchild_reg, lchild_next;
    logic             out_valid_reg, out_valid_next;
    logic [55:0]      out_data_reg, out_data_next;

    // Memory ports.
    logic             h_we;
    logic [SW-1:0]    h_waddr, h_raddr;
    logic [IW+KW-1:0] h_wdata, h_rdata;
    logic             h_we2;
    logic [SW-1:0]    h_waddr2;
    logic [IW+KW-1:0] h_wdata2;
    logic             p_we, p_we2;
    logic [IW-1:0]    p_waddr, p_waddr2, p_raddr;
    logic [SW-1:0]    p_wdata, p_wdata2, p_rdata;

    // Slot memory: two write ports only when a swap lands; modeled as array.
    always_ff @(posedge clk)
    begin
        if (h_we)
            heap_mem[h_waddr] <= h_wdata;
        if (h_we2)
            heap_mem[h_waddr2] <= h_wdata2;
        h_rdata <= heap_mem[h_raddr];
    end

    // Position memory.
    always_ff @(posedge clk)
    begin
        if (p_we)
            pos_mem[p_waddr] <= p_wdata;
        if (p_we2)
            pos_mem[p_waddr2] <= p_wdata2;
        p_rdata <= pos_mem[p_raddr];
    end

    wire s_fire = s_axis_tvalid && s_axis_tready;
    wire m_fire = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (state_reg == ibmh_pkg::S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ibmh_pkg::S_IDLE;
            present_reg   <= '0;
            cnt_reg       <= '0;
            desc_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                desc_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        id_reg       <= id_next;
        key_reg      <= key_next;
        mid_reg      <= mid_next;
        cur_reg      <= cur_next;
        st_reg       <= st_next;
        lchild_reg   <= lchild_next;
        out_data_reg <= out_data_next;
    end

    // Derived slots.
    logic [SW-1:0] parent_s, lchild_s, rchild_s, last_s;
    logic [SW:0]   l_full, r_full;
    always_comb
    begin
        parent_s = SW'((cur_reg - 1'b1) >> 1);
        l_full   = {cur_reg, 1'b1};
        r_full   = l_full + 1'b1;
        lchild_s = l_full[SW-1:0];
        rchild_s = r_full[SW-1:0];
        last_s   = SW'(cnt_reg - 1'b1);
    end
    wire l_in = ({1'b0, l_full} < {1'b0, cnt_reg});
    wire r_in = ({1'b0, r_full} < {1'b0, cnt_reg});
    wire [KW-1:0] rd_key = h_rdata[KW-1:0];
    wire [IW-1:0] rd_id  = h_rdata[IW+KW-1:KW];
    wire [KW-1:0] lc_key = lchild_reg[KW-1:0];
    wire [IW-1:0] lc_id  = lchild_reg[IW+KW-1:KW];

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        cnt_next       = cnt_reg;
        act_next       = act_reg;
        id_next        = id_reg;
        key_next       = key_reg;
        mid_next       = mid_reg;
        cur_next       = cur_reg;
        st_next        = st_reg;
        lchild_next    = lchild_reg;
        out_valid_next = out_valid_reg && !m_fire;
        out_data_next  = out_data_reg;
        h_we = 1'b0; h_waddr = cur_reg; h_wdata = {mid_reg, key_reg};
        h_we2 = 1'b0; h_waddr2 = cur_reg; h_wdata2 = h_rdata;
        h_raddr = cur_reg;
        p_we = 1'b0; p_waddr = mid_reg; p_wdata = cur_reg;
        p_we2 = 1'b0; p_waddr2 = rd_id; p_wdata2 = cur_reg;
        p_raddr = id_reg;
        case (state_reg)
            ibmh_pkg::S_IDLE:
            begin
                if (s_fire)
                begin
                    act_next = s_axis_tdata[1:0];
                    id_next  = s_axis_tdata[7:2];
                    key_next = s_axis_tdata[39:8];
                    mid_next = s_axis_tdata[7:2];
                    st_next  = ibmh_pkg::ST_OK;
                    p_raddr  = s_axis_tdata[7:2];
                    state_next = ibmh_pkg::S_LOOKUP;
                end
            end
            ibmh_pkg::S_LOOKUP:
            begin
                case (act_reg)
                    ibmh_pkg::ACT_PUSH:
                    begin
                        if (cnt_reg >= ibmh_pkg::CAPACITY)
                        begin
                            st_next = ibmh_pkg::ST_FULL;
                            state_next = ibmh_pkg::S_TOP_READ;
                        end
                        else if (present_reg[id_reg])
                        begin
                            st_next = ibmh_pkg::ST_DUP;
                            state_next = ibmh_pkg::S_TOP_READ;
                        end
                        else
                        begin
                            cur_next = SW'(cnt_reg);
                            cnt_next = cnt_reg + 1'b1;
                            present_next[id_reg] = 1'b1;
                            h_we = 1'b1; h_waddr = SW'(cnt_reg);
                            p_we = 1'b1; p_waddr = id_reg; p_wdata = SW'(cnt_reg);
                            state_next = ibmh_pkg::S_UP_READ;
                        end
                    end
                    ibmh_pkg::ACT_DECREASE:
                    begin
                        if (!present_reg[id_reg])
                        begin
                            st_next = ibmh_pkg::ST_ABSENT;
                            state_next = ibmh_pkg::S_TOP_READ;
                        end
                        else
                        begin
                            cur_next = p_rdata;
                            h_raddr = p_rdata;
                            state_next = ibmh_pkg::S_DEC_CHECK;
                        end
                    end
                    ibmh_pkg::ACT_POP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            st_next = ibmh_pkg::ST_EMPTY;
                            state_next = ibmh_pkg::S_TOP_READ;
                        end
                        else
                        begin
                            h_raddr = last_s;
                            state_next = ibmh_pkg::S_POP_LAST;
                        end
                    end
                    default:
                        state_next = ibmh_pkg::S_TOP_READ;
                endcase
            end
            ibmh_pkg::S_DEC_CHECK:
            begin
                if (!ibmh_pkg::before_eq(desc_reg, key_reg, rd_key))
                begin
                    st_next = ibmh_pkg::ST_NOT_IMPR;
                    state_next = ibmh_pkg::S_TOP_READ;
                end
                else
                begin
                    h_we = 1'b1;
                    state_next = ibmh_pkg::S_UP_READ;
                end
            end
            ibmh_pkg::S_POP_LAST:
            begin
                // h_rdata is the last entry; remove root and carry last down.
                h_raddr = '0;
                mid_next = rd_id;
                key_next = rd_key;
                state_next = ibmh_pkg::S_POP_ROOT;
            end
            ibmh_pkg::S_POP_ROOT:
            begin
                present_next[rd_id] = 1'b0;
                cnt_next = cnt_reg - 1'b1;
                cur_next = '0;
                if (cnt_reg == CW'(1))
                    state_next = ibmh_pkg::S_TOP_READ;
                else
                begin
                    h_we = 1'b1; h_waddr = '0;
                    p_we = 1'b1; p_wdata = '0;
                    state_next = ibmh_pkg::S_DN_READ_L;
                end
            end
            ibmh_pkg::S_UP_READ:
            begin
                if (cur_reg == '0)
                    state_next = ibmh_pkg::S_TOP_READ;
                else
                begin
                    h_raddr = parent_s;
                    state_next = ibmh_pkg::S_UP_CMP;
                end
            end
            ibmh_pkg::S_UP_CMP:
            begin
                if (ibmh_pkg::before_eq(desc_reg, key_reg, rd_key))
                begin
                    // Parent moves down, moving entry goes up.
                    h_we = 1'b1; h_waddr = parent_s;
                    h_we2 = 1'b1; h_waddr2 = cur_reg; h_wdata2 = h_rdata;
                    p_we = 1'b1; p_wdata = parent_s;
                    p_we2 = 1'b1; p_waddr2 = rd_id; p_wdata2 = cur_reg;
                    cur_next = parent_s;
                    state_next = ibmh_pkg::S_UP_READ;
                end
                else
                    state_next = ibmh_pkg::S_TOP_READ;
            end
            ibmh_pkg::S_DN_READ_L:
            begin
                if (!l_in)
                    state_next = ibmh_pkg::S_TOP_READ;
                else
                begin
                    h_raddr = lchild_s;
                    state_next = ibmh_pkg::S_DN_READ_R;
                end
            end
            ibmh_pkg::S_DN_READ_R:
            begin
                lchild_next = h_rdata;
                h_raddr = rchild_s;
                state_next = ibmh_pkg::S_DN_CMP;
            end
            ibmh_pkg::S_DN_CMP:
            begin
                // Pick child: right if present and before-or-equal left.
                if (r_in && ibmh_pkg::before_eq(desc_reg, rd_key, lc_key))
                begin
                    if (ibmh_pkg::before_eq(desc_reg, rd_key, key_reg))
                    begin
                        h_we = 1'b1; h_waddr = rchild_s;
                        h_we2 = 1'b1; h_waddr2 = cur_reg; h_wdata2 = h_rdata;
                        p_we = 1'b1; p_wdata = rchild_s;
                        p_we2 = 1'b1; p_waddr2 = rd_id; p_wdata2 = cur_reg;
                        cur_next = rchild_s;
                        state_next = ibmh_pkg::S_DN_READ_L;
                    end
                    else
                        state_next = ibmh_pkg::S_TOP_READ;
                end
                else if (ibmh_pkg::before_eq(desc_reg, lc_key, key_reg))
                begin
                    h_we = 1'b1; h_waddr = lchild_s;
                    h_we2 = 1'b1; h_waddr2 = cur_reg; h_wdata2 = lchild_reg;
                    p_we = 1'b1; p_wdata = lchild_s;
                    p_we2 = 1'b1; p_waddr2 = lc_id; p_wdata2 = cur_reg;
                    cur_next = lchild_s;
                    state_next = ibmh_pkg::S_DN_READ_L;
                end
                else
                    state_next = ibmh_pkg::S_TOP_READ;
            end
            ibmh_pkg::S_TOP_READ:
            begin
                h_raddr = '0;
                state_next = ibmh_pkg::S_TOP_WAIT;
            end
            ibmh_pkg::S_TOP_WAIT:
            begin
                // Keep the root address so the read data stays on the root.
                h_raddr = '0;
                state_next = ibmh_pkg::S_OUT;
            end
            ibmh_pkg::S_OUT:
            begin
                // Output register is free here: ready waited for it in idle.
                out_valid_next = 1'b1;
                out_data_next = '0;
                out_data_next[2:0] = st_reg;
                out_data_next[3] = (cnt_reg != '0);
                if (cnt_reg != '0)
                begin
                    out_data_next[9:4]   = rd_id;
                    out_data_next[41:10] = rd_key;
                end
                out_data_next[48:42] = cnt_reg;
                out_data_next[49]    = present_reg[id_reg];
                state_next = ibmh_pkg::S_IDLE;
            end
            default:
                state_next = ibmh_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
